FILE: rtl/pidc_pkg.sv
// shared types, constants and codes for the clamped pid controller
`timescale 1ns / 1ps

package pidc_pkg;

  // field widths
  localparam int WORD_W   = 32;               // q16.16 errors, gains, limits, drive
  localparam int DT_W     = 24;               // unsigned q8.16 interval
  localparam int CLAMP_W  = 2;
  localparam int INDEX_W  = 3;

  // integral width default and its sign-extended span for the multiplier
  localparam int INTEGRAL_WIDTH_DEF = 48;
  localparam int SPAN_W   = 64;

  // shared 33x32 signed multiplier
  localparam int MUL_A_W  = WORD_W + 1;
  localparam int MUL_B_W  = WORD_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;

  // exact control sum: three 64x32 products
  localparam int ACC_W    = SPAN_W + WORD_W + 2;

  // derivative divider
  localparam int FRAC_W   = 16;
  localparam int QUO_W    = WORD_W + FRAC_W;  // quotient magnitude
  localparam int DERIV_W  = QUO_W + 1;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [INDEX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [INDEX_W-1:0] REG_LIMIT_HIGH = 3'd3;
  localparam logic [INDEX_W-1:0] REG_LIMIT_LOW  = 3'd4;

  // clamp codes
  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

  // multiplier operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE = 3'd0;
  localparam logic [OP_W-1:0] OP_INC  = 3'd1;  // error * interval
  localparam logic [OP_W-1:0] OP_EGP  = 3'd2;  // error * gain_p
  localparam logic [OP_W-1:0] OP_ILO  = 3'd3;  // integral low word * gain_i
  localparam logic [OP_W-1:0] OP_IHI  = 3'd4;  // integral high word * gain_i
  localparam logic [OP_W-1:0] OP_DLO  = 3'd5;  // derivative low word * gain_d
  localparam logic [OP_W-1:0] OP_DHI  = 3'd6;  // derivative high word * gain_d

  typedef struct packed {
    logic signed [WORD_W-1:0] error_sample;
    logic        [DT_W-1:0]   time_step;
  } sample_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] drive;
    logic        [CLAMP_W-1:0] clamp_state;
  } result_t;

  typedef struct packed {
    logic            load;     // latch a new sample, start divider
    logic [OP_W-1:0] mul_op;   // operation issued to the multiplier
    logic            capture;  // load the output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

FILE: rtl/pidc_divider.sv
// restoring divider for the derivative term, one quotient bit per cycle
`timescale 1ns / 1ps

module pidc_divider (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [pidc_pkg::QUO_W-1:0]            num_mag,
  input  logic                                  neg,
  input  logic [pidc_pkg::DT_W-1:0]             divisor,
  output logic                                  busy,
  output logic signed [pidc_pkg::DERIV_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(pidc_pkg::QUO_W + 1);
  localparam int DT_W  = pidc_pkg::DT_W;

  logic [CNT_W-1:0]            count;
  logic [pidc_pkg::QUO_W-1:0]  quo;
  logic [DT_W-1:0]             rem;
  logic [DT_W-1:0]             dsr;
  logic                        neg_q;

  logic [DT_W:0]   shifted;
  logic [DT_W+1:0] trial;
  logic            fits;

  always_comb begin
    shifted = {rem, quo[pidc_pkg::QUO_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr};
    fits    = ~trial[DT_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      dsr   <= divisor;
      rem   <= '0;
      // zero interval gives a zero derivative
      if (divisor == '0) begin
        quo   <= '0;
        neg_q <= 1'b0;
        busy  <= 1'b0;
        count <= '0;
      end else begin
        quo   <= num_mag;
        neg_q <= neg;
        busy  <= 1'b1;
        count <= CNT_W'(pidc_pkg::QUO_W);
      end
    end else if (busy) begin
      rem   <= fits ? trial[DT_W-1:0] : shifted[DT_W-1:0];
      quo   <= {quo[pidc_pkg::QUO_W-2:0], fits};
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // truncation toward zero: divide magnitudes, then restore the sign
  assign quotient = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

FILE: rtl/pidc_datapath.sv
// datapath: config registers, state, shared multiplier, accumulator and clamp
`timescale 1ns / 1ps

module pidc_datapath #(
  parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pidc_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [pidc_pkg::WORD_W-1:0]        cfg_data,
  input  pidc_pkg::sample_t                  sample,
  input  pidc_pkg::cmd_t                     cmd,
  output pidc_pkg::status_t                  status,
  output pidc_pkg::result_t                  result
);

  localparam int WORD_W  = pidc_pkg::WORD_W;
  localparam int ACC_W   = pidc_pkg::ACC_W;
  localparam int PROD_W  = pidc_pkg::PROD_W;
  localparam int SPAN_W  = pidc_pkg::SPAN_W;
  localparam int FRAC_W  = pidc_pkg::FRAC_W;
  localparam int INC_W   = WORD_W + pidc_pkg::DT_W - FRAC_W;  // 40 bit increment
  localparam int SAT_W   = SPAN_W + 1;

  localparam logic signed [SAT_W-1:0] INT_MAX =
    $signed({{(SAT_W - INTEGRAL_WIDTH + 1){1'b0}}, {(INTEGRAL_WIDTH - 1){1'b1}}});
  localparam logic signed [SAT_W-1:0] INT_MIN = ~INT_MAX;

  // configuration
  logic signed [WORD_W-1:0] gain_p, gain_i, gain_d, limit_high, limit_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      limit_high <= '0;
      limit_low  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pidc_pkg::REG_GAIN_P:     gain_p     <= cfg_data;
        pidc_pkg::REG_GAIN_I:     gain_i     <= cfg_data;
        pidc_pkg::REG_GAIN_D:     gain_d     <= cfg_data;
        pidc_pkg::REG_LIMIT_HIGH: limit_high <= cfg_data;
        pidc_pkg::REG_LIMIT_LOW:  limit_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample latch and difference for the derivative
  logic signed [WORD_W-1:0]        err_q;
  logic [pidc_pkg::DT_W-1:0]       dt_q;
  logic signed [WORD_W-1:0]        previous_error;
  logic signed [INTEGRAL_WIDTH-1:0] integral_sum;

  logic signed [WORD_W:0] diff;
  logic [WORD_W:0]        diff_mag;

  always_comb begin
    diff     = (WORD_W+1)'(sample.error_sample) - (WORD_W+1)'(previous_error);
    diff_mag = diff[WORD_W] ? 33'(-diff) : 33'(diff);
  end

  logic signed [pidc_pkg::DERIV_W-1:0] deriv;

  pidc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.load),
    .num_mag  ({diff_mag[WORD_W-1:0], {FRAC_W{1'b0}}}),
    .neg      (diff[WORD_W]),
    .divisor  (sample.time_step),
    .busy     (status.div_busy),
    .quotient (deriv)
  );

  // shared multiplier, product registered with the op that made it
  logic signed [SPAN_W-1:0] integ_span, deriv_span;
  logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_full;
  logic signed [PROD_W-1:0] prod;
  logic [pidc_pkg::OP_W-1:0] op_q;

  always_comb begin
    integ_span = SPAN_W'(integral_sum);
    deriv_span = SPAN_W'(deriv);
    unique case (cmd.mul_op)
      pidc_pkg::OP_INC: begin
        mul_a = {err_q[WORD_W-1], err_q};
        mul_b = $signed({{(WORD_W - pidc_pkg::DT_W){1'b0}}, dt_q});
      end
      pidc_pkg::OP_EGP: begin
        mul_a = {err_q[WORD_W-1], err_q};
        mul_b = gain_p;
      end
      pidc_pkg::OP_ILO: begin
        mul_a = $signed({1'b0, integ_span[WORD_W-1:0]});
        mul_b = gain_i;
      end
      pidc_pkg::OP_IHI: begin
        mul_a = {integ_span[SPAN_W-1], integ_span[SPAN_W-1:WORD_W]};
        mul_b = gain_i;
      end
      pidc_pkg::OP_DLO: begin
        mul_a = $signed({1'b0, deriv_span[WORD_W-1:0]});
        mul_b = gain_d;
      end
      pidc_pkg::OP_DHI: begin
        mul_a = {deriv_span[SPAN_W-1], deriv_span[SPAN_W-1:WORD_W]};
        mul_b = gain_d;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= pidc_pkg::OP_NONE;
    end else begin
      op_q <= cmd.mul_op;
    end
    prod <= mul_full;
  end

  // integral update: floor of error*interval in q16, then saturate
  logic signed [INC_W-1:0] inc;
  logic signed [SAT_W-1:0] int_sum;
  logic signed [INTEGRAL_WIDTH-1:0] int_next;

  always_comb begin
    inc     = prod[INC_W+FRAC_W-1:FRAC_W];
    int_sum = SAT_W'(integral_sum) + SAT_W'(inc);
    if (int_sum > INT_MAX) begin
      int_next = INT_MAX[INTEGRAL_WIDTH-1:0];
    end else if (int_sum < INT_MIN) begin
      int_next = INT_MIN[INTEGRAL_WIDTH-1:0];
    end else begin
      int_next = int_sum[INTEGRAL_WIDTH-1:0];
    end
  end

  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (op_q == pidc_pkg::OP_INC) begin
      previous_error <= err_q;
      integral_sum   <= int_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_q <= sample.error_sample;
      dt_q  <= sample.time_step;
      acc   <= '0;
    end else begin
      unique case (op_q)
        pidc_pkg::OP_EGP, pidc_pkg::OP_ILO, pidc_pkg::OP_DLO:
          acc <= acc + ACC_W'(prod);
        pidc_pkg::OP_IHI, pidc_pkg::OP_DHI:
          acc <= acc + (ACC_W'(prod) <<< WORD_W);
        default: ;
      endcase
    end
  end

  // exact compare against the limits, high limit first
  logic signed [ACC_W-1:0] hi_ext, lo_ext;

  always_comb begin
    hi_ext = ACC_W'(limit_high) <<< FRAC_W;
    lo_ext = ACC_W'(limit_low) <<< FRAC_W;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      priority if (acc >= hi_ext) begin
        result.drive       <= limit_high;
        result.clamp_state <= pidc_pkg::CLAMP_HIGH;
      end else if (acc <= lo_ext) begin
        result.drive       <= limit_low;
        result.clamp_state <= pidc_pkg::CLAMP_LOW;
      end else begin
        result.drive       <= acc[WORD_W+FRAC_W-1:FRAC_W];
        result.clamp_state <= pidc_pkg::CLAMP_NONE;
      end
    end
  end

endmodule

FILE: rtl/pidc_ctrl.sv
// controller: sequences one sample through the datapath, owns the handshakes
`timescale 1ns / 1ps

module pidc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  pidc_pkg::status_t  status,
  output pidc_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INC   = 4'd1;
  localparam logic [3:0] S_EGP   = 4'd2;
  localparam logic [3:0] S_ILO   = 4'd3;
  localparam logic [3:0] S_IHI   = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_DLO   = 4'd6;
  localparam logic [3:0] S_DHI   = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_CLAMP = 4'd9;

  logic [3:0] state, state_next;
  logic       result_valid_next;

  assign sample_ready = (state == S_IDLE);

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid & ~result_ready;
    cmd.load          = 1'b0;
    cmd.mul_op        = pidc_pkg::OP_NONE;
    cmd.capture       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = S_INC;
        end
      end
      S_INC: begin
        cmd.mul_op = pidc_pkg::OP_INC;
        state_next = S_EGP;
      end
      S_EGP: begin
        cmd.mul_op = pidc_pkg::OP_EGP;
        state_next = S_ILO;
      end
      S_ILO: begin
        cmd.mul_op = pidc_pkg::OP_ILO;
        state_next = S_IHI;
      end
      S_IHI: begin
        cmd.mul_op = pidc_pkg::OP_IHI;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_DLO;
        end
      end
      S_DLO: begin
        cmd.mul_op = pidc_pkg::OP_DLO;
        state_next = S_DHI;
      end
      S_DHI: begin
        cmd.mul_op = pidc_pkg::OP_DHI;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        if (!result_valid || result_ready) begin
          cmd.capture       = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

FILE: rtl/pid_controller_clamped.sv
// top level of the discrete pid controller with output clamp
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   sample   | sample_valid/ready       | error_sample q16.16, time_step q8.16
//   result   | result_valid/ready       | drive q16.16, clamp_state
//   config   | cfg_valid/ready          | cfg_index, cfg_data (always ready)
//
// nonzero interval: the result waits for the 48-bit serial divider, then
// two products, a drain and the clamp; a zero interval skips the divider wait
// synchronous active-high reset clears gains, limits, previous error and
// integral, and empties the output register
// a finished result waits in the output register; the next sample is taken
// as it appears and the controller stalls at the clamp step while it is full
`timescale 1ns / 1ps

module pid_controller_clamped #(
  parameter int INTEGRAL_WIDTH = pidc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample transaction
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  pidc_pkg::sample_t             sample,
  // result transaction
  output logic                          result_valid,
  input  logic                          result_ready,
  output pidc_pkg::result_t             result,
  // register write transaction
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pidc_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::WORD_W-1:0]   cfg_data
);

  pidc_pkg::cmd_t    cmd;
  pidc_pkg::status_t status;

  // register writes take effect at the next clock edge, no back pressure
  assign cfg_ready = 1'b1;

  pidc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  pidc_datapath #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

FILE: dv/pid_drive_checker.sv
// checker that predicts each pid controller result and compares it with the block
`timescale 1ns / 1ps

module pid_drive_checker
  import pidc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_ready,
  input  sample_t            sample,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_t            result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]  cfg_data,
  output int                 mismatches,
  output int                 outstanding
);

  typedef logic signed [127:0] exact_t;

  localparam longint INTEG_MAX = (longint'(1) <<< (INTEGRAL_WIDTH_DEF - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  logic signed [WORD_W-1:0] kp, ki, kd, lim_hi, lim_lo;
  longint                   last_error;
  longint                   integral;
  result_t                  drive_queue[$];

  // one control step: updates the error history and integral, returns the output
  function automatic result_t control_law(input sample_t s);
    longint  e, dt, slope, step;
    exact_t  total, hi_bound, lo_bound;
    result_t r;
    e  = longint'($signed(s.error_sample));
    dt = longint'(s.time_step);
    slope = (dt > 0) ? ((e - last_error) * 65536) / dt : 0;
    // floor of e*dt back to q.16, sum saturates at the integral width
    step = (e * dt) >>> FRAC_W;
    if (step > 0 && integral > INTEG_MAX - step)
      integral = INTEG_MAX;
    else if (step < 0 && integral < INTEG_MIN - step)
      integral = INTEG_MIN;
    else
      integral = integral + step;
    last_error = e;
    total = exact_t'(e) * exact_t'(kp) + exact_t'(integral) * exact_t'(ki)
          + exact_t'(slope) * exact_t'(kd);
    hi_bound = exact_t'(lim_hi) <<< FRAC_W;
    lo_bound = exact_t'(lim_lo) <<< FRAC_W;
    if (total >= hi_bound) begin
      r.drive       = lim_hi;
      r.clamp_state = CLAMP_HIGH;
    end else if (total <= lo_bound) begin
      r.drive       = lim_lo;
      r.clamp_state = CLAMP_LOW;
    end else begin
      r.drive       = total[FRAC_W +: WORD_W];
      r.clamp_state = CLAMP_NONE;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      kp         = '0;
      ki         = '0;
      kd         = '0;
      lim_hi     = '0;
      lim_lo     = '0;
      last_error = 0;
      integral   = 0;
      drive_queue.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (drive_queue.size() == 0) begin
          log_mismatch($sformatf("unexpected result: drive %h clamp %0d",
                                 result.drive, result.clamp_state));
        end else begin
          want = drive_queue.pop_front();
          if (result.drive !== want.drive)
            log_mismatch($sformatf("drive: expected %h, got %h", want.drive, result.drive));
          if (result.clamp_state !== want.clamp_state)
            log_mismatch($sformatf("clamp_state: expected %0d, got %0d",
                                   want.clamp_state, result.clamp_state));
        end
      end
      if (sample_valid && sample_ready)
        drive_queue.push_back(control_law(sample));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:     kp     = cfg_data;
          REG_GAIN_I:     ki     = cfg_data;
          REG_GAIN_D:     kd     = cfg_data;
          REG_LIMIT_HIGH: lim_hi = cfg_data;
          REG_LIMIT_LOW:  lim_lo = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = drive_queue.size();
  end

endmodule

FILE: dv/tb_top.sv
// testbench top for the clamped pid controller: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
  import pidc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;    // a little more than one sample's latency
  localparam int LONG_HOLD    = 400;   // result side stall, several samples long
  localparam int HOLD_AFTER   = 150;   // results taken before the long stall
  localparam int FREE_ITEMS   = 60;
  localparam int RISE_ITEMS   = 330;   // enough to drive the integral to its top rail
  localparam int FALL_ITEMS   = 620;   // and from there all the way to the bottom rail

  localparam logic [WORD_W-1:0]  WORD_MAX      = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0]  WORD_MIN      = 32'h8000_0000;
  localparam logic [WORD_W-1:0]  Q_ONE         = 32'h0001_0000;
  localparam logic [DT_W-1:0]    DT_MAX        = '1;
  localparam logic [DT_W-1:0]    DT_ONE        = 24'h01_0000;
  localparam logic [INDEX_W-1:0] REG_SPARE_TOP = '1;

  // which way the random errors lean
  typedef enum logic [1:0] {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_t;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  sample_t            sample;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]  cfg_data;

  int                mismatches;
  int                outstanding;
  int                cycles;
  bit                idle_on;
  logic [WORD_W-1:0] last_sent;

  pid_controller_clamped u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pid_drive_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // whole units to q16.16
  function automatic logic [WORD_W-1:0] q16(input int units);
    return WORD_W'(units * 65536);
  endfunction

  function automatic sample_t mk(input logic [WORD_W-1:0] e, input logic [DT_W-1:0] dt);
    sample_t s;
    s.error_sample = e;
    s.time_step    = dt;
    return s;
  endfunction

  // random value within +-2.0
  function automatic logic [WORD_W-1:0] small_q();
    return $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
  endfunction

  function automatic logic [WORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return Q_ONE;
      default: return '1;
    endcase
  endfunction

  // random sample; a drift pushes the integral steadily toward one rail
  function automatic sample_t pick_sample(input drift_t drift);
    sample_t s;
    s.error_sample = $urandom;
    s.time_step    = DT_W'($urandom);
    if (drift != DRIFT_NONE && $urandom_range(0, 15) != 0) begin
      s.time_step    = DT_W'($urandom_range(DT_MAX, 24'hF0_0000));
      s.error_sample = (drift == DRIFT_UP) ? $urandom_range(WORD_MAX, 32'h7800_0000)
                                           : $urandom_range(32'h87FF_FFFF, WORD_MIN);
      return s;
    end
    case ($urandom_range(0, 7))
      0:       s.error_sample = small_q();
      1:       s.error_sample = pick_extreme();
      2:       s.error_sample = last_sent;  // unchanged error, flat derivative
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0:       s.time_step = '0;
      1:       s.time_step = DT_W'($urandom_range(1, 255));
      2:       s.time_step = DT_ONE;
      3:       s.time_step = DT_MAX;
      default: ;
    endcase
    return s;
  endfunction

  // offer one sample and hold it until the block takes it; valid is left high
  // so the next sample can follow with no gap
  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      // short idle burst before the next offer
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    last_sent     = s.error_sample;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic send_random(input int count, input drift_t drift);
    repeat (count) send_sample(pick_sample(drift));
  endtask

  // stop offering samples and wait until every result is back
  task automatic settle();
    sample_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic put_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, written only once the controller is idle
  task automatic load_settings(input logic [WORD_W-1:0] gp, gi, gd, hi, lo);
    settle();
    // a write to an unused index must change nothing
    put_reg(INDEX_W'($urandom_range(REG_LIMIT_LOW + 1, REG_SPARE_TOP)), $urandom);
    put_reg(REG_GAIN_P, gp);
    put_reg(REG_GAIN_I, gi);
    put_reg(REG_GAIN_D, gd);
    put_reg(REG_LIMIT_HIGH, hi);
    put_reg(REG_LIMIT_LOW, lo);
    cfg_valid <= 1'b0;
  endtask

  // result side: short random stalls plus one long stall that backs up the block
  initial begin
    int taken;
    bit held;
    taken = 0;
    held  = 1'b0;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      if (result_valid && result_ready)
        taken++;
    end
  end

  // stimulus and verdict
  initial begin
    logic [WORD_W-1:0] span;
    idle_on       = 1'b1;
    last_sent     = '0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // all three terms active, wide limits; field extremes and a zero interval
    load_settings(Q_ONE, Q_ONE >> 1, Q_ONE >> 2, q16(100), q16(-100));
    send_sample(mk('0, '0));
    send_sample(mk(WORD_MAX, DT_MAX));
    send_sample(mk(WORD_MIN, DT_MAX));
    send_sample(mk(WORD_MIN, '0));
    send_sample(mk(WORD_MAX, 24'd1));
    send_sample(mk('1, 24'd1));
    send_sample(mk(Q_ONE, DT_ONE));
    send_sample(mk(Q_ONE, DT_ONE));
    send_sample(mk(q16(-3), 24'h00_8000));

    // proportional only: output equals the error, so limits are hit exactly
    load_settings(Q_ONE, '0, '0, q16(10), q16(-10));
    send_sample(mk(q16(10), '0));
    send_sample(mk(q16(-10), '0));
    send_sample(mk(q16(10) - 1, '0));
    send_sample(mk(q16(-10) + 1, '0));
    send_sample(mk(q16(11), DT_ONE));

    // crossed limits: the high clamp wins whenever both apply
    load_settings(Q_ONE, '0, '0, q16(-5), q16(5));
    send_sample(mk('0, '0));
    send_sample(mk(q16(-6), '0));
    send_sample(mk(q16(-5), '0));

    // largest gains and limits
    load_settings(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
    send_sample(mk(WORD_MAX, DT_MAX));
    send_sample(mk(WORD_MIN, 24'd1));
    send_sample(mk(WORD_MAX, '0));
    send_sample(mk('0, DT_MAX));

    // random: moderate gains, symmetric limits
    span = $urandom_range(0, WORD_MAX);
    load_settings(small_q(), small_q(), small_q(), span, ~span);
    send_random(FREE_ITEMS, DRIFT_NONE);

    // random: gains at the opposite extremes
    load_settings(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
    send_random(FREE_ITEMS, DRIFT_NONE);

    // random: crossed or equal limits, any gains
    span = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
    load_settings($urandom, $urandom, $urandom, span,
                  span + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 32'h10_0000)));
    send_random(FREE_ITEMS, DRIFT_NONE);

    // integral pushed into positive saturation, then negative
    load_settings(small_q(), $urandom_range(0, 255), small_q(), WORD_MAX, WORD_MIN);
    send_random(RISE_ITEMS, DRIFT_UP);
    load_settings(small_q(), $urandom_range(0, 255), small_q(), pick_extreme(), pick_extreme());
    send_random(FALL_ITEMS, DRIFT_DOWN);

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    load_settings($urandom, $urandom, $urandom, $urandom, $urandom);
    send_random(FREE_ITEMS, DRIFT_NONE);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
